@@ hdl/assim_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// assim_pkg
// shared types and constants of the allele sharing similarity block
// ----------------------------------------------------------------------------
package assim_pkg;

	localparam int ALLELE_W  = 8;
	localparam int CNT_W     = 26;
	localparam int FRAC_W    = 16;
	localparam int SIM_W     = FRAC_W + 1;
	localparam int NUM_W     = CNT_W + FRAC_W + 1;
	localparam int DIV_STEPS = SIM_W;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	localparam logic [SIM_W-1:0] SIM_ONE = SIM_W'(1) << FRAC_W;
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_LOAD = 4'b0010,
		S_DIV  = 4'b0100,
		S_FIN  = 4'b1000
	} state_t;

	typedef struct packed {
		logic accum;
		logic finish;
		logic load;
		logic step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} sts_t;

endpackage

@@ hdl/allele_sharing_similarity.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// allele_sharing_similarity
// identity-by-state similarity of one pair of individuals over streamed loci
// ----------------------------------------------------------------------------
// Input beats carry one locus: four allele codes in s_axis_tdata, 0 missing,
// and s_axis_tlast on the final locus of the pair. A non-last beat is taken
// while the sequencer is idle and folded into the saturating compared/shared totals.
// On a last beat the totals are latched and cleared, then a bit-serial
// restoring divider forms shared/compared in Q1.16, one quotient bit a
// cycle. After the last beat the input stalls through the load state, the
// 17 divide steps and the handoff state; the next pair's first beat is
// taken only once the sequencer is idle again. The result is loaded into
// the output register (m_axis) from the handoff state after the last step.
// The result sits in an output register. If the receiver stalls, the
// sequencer holds in its handoff state until the register frees up; the
// input stays stalled meanwhile. no_data travels on m_axis_tuser.
// cfg_we/cfg_wdata write diploid_mode (reset 1); write only while idle.
// Reset clears the totals and the output valid and sets diploid mode.
// ----------------------------------------------------------------------------
module allele_sharing_similarity
	import assim_pkg::*;
#(
	parameter int ALLELE_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// first_allele_a, second_allele_a, first_allele_b, second_allele_b
	input  logic [31:0] s_axis_tdata,
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// compared_count, shared_count, similarity, zero pad
	output logic [71:0] m_axis_tdata,
	// no_data
	output logic [0:0]  m_axis_tuser
);

	cmd_t             cmd;
	sts_t             sts;
	logic [CNT_W-1:0] compared_count;
	logic [CNT_W-1:0] shared_count;
	logic [SIM_W-1:0] similarity;
	logic             no_data;

	assim_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_last  (s_axis_tlast),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	assim_dp #(
		.ALLELE_BITS (ALLELE_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.first_allele_a  (s_axis_tdata[7:0]),
		.second_allele_a (s_axis_tdata[15:8]),
		.first_allele_b  (s_axis_tdata[23:16]),
		.second_allele_b (s_axis_tdata[31:24]),
		.cmd             (cmd),
		.sts             (sts),
		.out_valid       (m_axis_tvalid),
		.out_ready       (m_axis_tready),
		.compared_count  (compared_count),
		.shared_count    (shared_count),
		.similarity      (similarity),
		.no_data         (no_data)
	);

	assign m_axis_tdata = {3'b000, similarity, shared_count, compared_count};
	assign m_axis_tuser = no_data;

`ifndef SYNTHESIS
	a_no_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> similarity == '0 && compared_count == '0)
		else $error("no_data result with nonzero fields");

	a_shared_le_compared: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> shared_count <= compared_count)
		else $error("shared count above compared count");

	a_sim_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> similarity <= SIM_ONE)
		else $error("similarity above one");

	a_last_stalls_input: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
		else $error("input taken during division");
`endif

endmodule

@@ hdl/assim_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// assim_ctrl
// sequencer: accumulate loci, then run the ratio division and hand off result
// ----------------------------------------------------------------------------
module assim_ctrl
	import assim_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_last,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t            state_q;
	state_t            state_nx;
	logic [STEP_W-1:0] step_q;
	logic              beat;
	logic              div_last;

	assign in_ready = (state_q == S_IDLE);
	assign beat     = in_valid && in_ready;
	assign div_last = (step_q == STEP_W'(DIV_STEPS - 1));

	always_comb begin
		cmd          = '0;
		cmd.accum    = beat;
		cmd.finish   = beat && in_last;
		cmd.load     = (state_q == S_LOAD);
		cmd.step     = (state_q == S_DIV);
		cmd.out_load = (state_q == S_FIN) && sts.out_free;
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (beat && in_last) state_nx = S_LOAD;
			end
			S_LOAD: state_nx = S_DIV;
			S_DIV: begin
				if (div_last) state_nx = S_FIN;
			end
			S_FIN: begin
				if (sts.out_free) state_nx = S_IDLE;
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == S_LOAD) step_q <= '0;
			else if (state_q == S_DIV) step_q <= step_q + STEP_W'(1);
		end
	end

endmodule

@@ hdl/assim_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// assim_dp
// allele compare, saturating totals, bit-serial divider and output register
// ----------------------------------------------------------------------------
module assim_dp
	import assim_pkg::*;
#(
	parameter int ALLELE_BITS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_wdata,
	input  logic [ALLELE_W-1:0] first_allele_a,
	input  logic [ALLELE_W-1:0] second_allele_a,
	input  logic [ALLELE_W-1:0] first_allele_b,
	input  logic [ALLELE_W-1:0] second_allele_b,
	input  cmd_t                cmd,
	output sts_t                sts,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [CNT_W-1:0]    compared_count,
	output logic [CNT_W-1:0]    shared_count,
	output logic [SIM_W-1:0]    similarity,
	output logic                no_data
);

	localparam int AB = (ALLELE_BITS > ALLELE_W) ? ALLELE_W : ALLELE_BITS;

	logic              diploid_q;
	logic [CNT_W-1:0]  cmp_tot_q;
	logic [CNT_W-1:0]  shr_tot_q;
	logic [CNT_W-1:0]  cmp_q;
	logic [CNT_W-1:0]  shr_q;
	logic [CNT_W-1:0]  rem_q;
	logic [SIM_W-1:0]  nlo_q;
	logic [SIM_W-1:0]  quo_q;
	logic              out_valid_q;
	logic [CNT_W-1:0]  out_cmp_q;
	logic [CNT_W-1:0]  out_shr_q;
	logic [SIM_W-1:0]  out_sim_q;
	logic              out_none_q;

	logic [AB-1:0]     a;
	logic [AB-1:0]     b;
	logic [AB-1:0]     c;
	logic [AB-1:0]     d;
	logic [1:0]        k;
	logic [1:0]        cmp_inc;
	logic [1:0]        shr_inc;
	logic [CNT_W:0]    cmp_sum;
	logic [CNT_W:0]    shr_sum;
	logic [CNT_W-1:0]  cmp_new;
	logic [CNT_W-1:0]  shr_new;
	logic [NUM_W-1:0]  num;
	logic [CNT_W:0]    shifted;
	logic              ge;
	logic [CNT_W:0]    diff;
	logic [SIM_W-1:0]  sim_fin;

	assign a = first_allele_a[AB-1:0];
	assign b = second_allele_a[AB-1:0];
	assign c = first_allele_b[AB-1:0];
	assign d = second_allele_b[AB-1:0];

	// homozygote rule for allele pairs
	always_comb begin
		if (a == b) k = 2'(a == c) + 2'(a == d);
		else if (c == d) k = 2'(c == a) + 2'(c == b);
		else k = 2'(a == c) + 2'(a == d) + 2'(b == c) + 2'(b == d);
	end

	always_comb begin
		cmp_inc = '0;
		shr_inc = '0;
		if (diploid_q) begin
			if (a != '0 && b != '0 && c != '0 && d != '0) begin
				cmp_inc = 2'd2;
				shr_inc = k;
			end
		end else begin
			if (a != '0 && c != '0) begin
				cmp_inc = 2'd1;
				shr_inc = 2'(a == c);
			end
		end
	end

	assign cmp_sum = {1'b0, cmp_tot_q} + (CNT_W + 1)'(cmp_inc);
	assign shr_sum = {1'b0, shr_tot_q} + (CNT_W + 1)'(shr_inc);
	assign cmp_new = cmp_sum[CNT_W] ? CNT_MAX : cmp_sum[CNT_W-1:0];
	assign shr_new = shr_sum[CNT_W] ? CNT_MAX : shr_sum[CNT_W-1:0];

	// numerator: shared scaled by 2^16 plus half the divisor for rounding
	assign num = {1'b0, shr_q, {FRAC_W{1'b0}}} + NUM_W'(cmp_q >> 1);

	assign shifted = {rem_q, nlo_q[SIM_W-1]};
	assign ge      = (shifted >= {1'b0, cmp_q});
	assign diff    = shifted - {1'b0, cmp_q};

	assign sim_fin = (cmp_q == '0) ? '0 : ((quo_q > SIM_ONE) ? SIM_ONE : quo_q);

	assign sts.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			diploid_q   <= 1'b1;
			cmp_tot_q   <= '0;
			shr_tot_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) diploid_q <= cfg_wdata;
			if (cmd.finish) begin
				cmp_tot_q <= '0;
				shr_tot_q <= '0;
			end else if (cmd.accum) begin
				cmp_tot_q <= cmp_new;
				shr_tot_q <= shr_new;
			end
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			cmp_q <= cmp_new;
			shr_q <= (shr_new > cmp_new) ? cmp_new : shr_new;
		end
		if (cmd.load) begin
			rem_q <= num[NUM_W-1:SIM_W];
			nlo_q <= num[SIM_W-1:0];
			quo_q <= '0;
		end else if (cmd.step) begin
			rem_q <= ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
			nlo_q <= {nlo_q[SIM_W-2:0], 1'b0};
			quo_q <= {quo_q[SIM_W-2:0], ge};
		end
		if (cmd.out_load) begin
			out_cmp_q  <= cmp_q;
			out_shr_q  <= shr_q;
			out_sim_q  <= sim_fin;
			out_none_q <= (cmp_q == '0);
		end
	end

	assign out_valid      = out_valid_q;
	assign compared_count = out_cmp_q;
	assign shared_count   = out_shr_q;
	assign similarity     = out_sim_q;
	assign no_data        = out_none_q;

endmodule

@@ dv/allele_sharing_similarity_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// allele_sharing_similarity_test
// self-checking bench for the allele sharing similarity block
// ----------------------------------------------------------------------------
// Loci are queued by a stimulus thread and sent by a clocked driver. Every
// accepted locus is folded into the bench's own compared/shared totals in
// haploid or diploid mode. On a last locus the expected counts and Q1.16
// ratio are queued. A clocked monitor checks each output beat against the
// oldest expectation. Directed pairs cover the homozygote rule, missing
// alleles, empty pairs, byte extremes and a mode switch inside a pair.
// Random phases follow, each in a random mode. Both sides idle at random.
// The receiver twice holds off for a long stretch so the block backs up.
// ----------------------------------------------------------------------------
module allele_sharing_similarity_test;
	import assim_pkg::*;

	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct {
		logic [ALLELE_W-1:0] fa;
		logic [ALLELE_W-1:0] sa;
		logic [ALLELE_W-1:0] fb;
		logic [ALLELE_W-1:0] sb;
		logic                last;
	} locus_t;

	typedef struct {
		logic [CNT_W-1:0] compared;
		logic [CNT_W-1:0] shared;
		logic [SIM_W-1:0] similarity;
		logic             no_data;
	} ratio_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_wdata = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [71:0] m_axis_tdata;
	logic [0:0]  m_axis_tuser;

	locus_t locus_queue[$];
	ratio_t expected_ratios[$];
	locus_t on_wire;

	logic             diploid_now = 1'b1;
	logic [CNT_W-1:0] compared_sum = '0;
	logic [CNT_W-1:0] shared_sum = '0;
	logic             steady = 1'b0;
	logic             offering;

	int loci_queued = 0;
	int loci_sent = 0;
	int ratios_seen = 0;
	int failures = 0;
	int send_gap = 0;
	int recv_stall = 0;
	int recv_hold = 0;
	int quiet_cycles = 0;

	allele_sharing_similarity uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] acc, input int inc);
		logic [CNT_W:0] sum;
		sum = {1'b0, acc} + (CNT_W + 1)'(inc);
		return sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
	endfunction

	// homozygote rule for a diploid locus
	function automatic int shared_alleles(input locus_t l);
		if (l.fa == l.sa)
			return int'(l.fa == l.fb) + int'(l.fa == l.sb);
		if (l.fb == l.sb)
			return int'(l.fb == l.fa) + int'(l.fb == l.sa);
		return int'(l.fa == l.fb) + int'(l.fa == l.sb) + int'(l.sa == l.fb) + int'(l.sa == l.sb);
	endfunction

	task automatic fold_locus(input locus_t l);
		ratio_t r;
		logic [63:0] scaled;
		if (diploid_now) begin
			if (l.fa != 0 && l.sa != 0 && l.fb != 0 && l.sb != 0) begin
				compared_sum = sat_add(compared_sum, 2);
				shared_sum = sat_add(shared_sum, shared_alleles(l));
			end
		end else if (l.fa != 0 && l.fb != 0) begin
			compared_sum = sat_add(compared_sum, 1);
			if (l.fa == l.fb)
				shared_sum = sat_add(shared_sum, 1);
		end
		if (l.last) begin
			r.compared = compared_sum;
			r.shared = (shared_sum > compared_sum) ? compared_sum : shared_sum;
			if (compared_sum == 0) begin
				r.similarity = '0;
				r.no_data = 1'b1;
			end else begin
				scaled = ((64'(r.shared) << FRAC_W) + 64'(compared_sum >> 1)) / 64'(compared_sum);
				r.similarity = (scaled > 64'(SIM_ONE)) ? SIM_ONE : scaled[SIM_W-1:0];
				r.no_data = 1'b0;
			end
			expected_ratios.insert(expected_ratios.size(), r);
			compared_sum = '0;
			shared_sum = '0;
		end
	endtask

	task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d actual %0d", $time, what, want, got);
			failures++;
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tlast <= 1'b0;
			send_gap = 0;
		end else begin
			offering = s_axis_tvalid;
			if (s_axis_tvalid && s_axis_tready) begin
				fold_locus(on_wire);
				loci_sent++;
				offering = 1'b0;
				send_gap = steady ? 0 : $urandom_range(0, 3);
			end
			if (!offering) begin
				if (send_gap > 0) begin
					send_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (locus_queue.size() > 0) begin
					on_wire = locus_queue.pop_front();
					s_axis_tdata <= {on_wire.sb, on_wire.fb, on_wire.sa, on_wire.fa};
					s_axis_tlast <= on_wire.last;
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		ratio_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			recv_stall = 0;
			recv_hold = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_ratios.size() == 0) begin
					$display("%0t: unexpected beat, expected none actual %h", $time, m_axis_tdata);
					failures++;
				end else begin
					want = expected_ratios.pop_front();
					check_field("compared_count", 32'(want.compared),
						32'(m_axis_tdata[CNT_W-1:0]));
					check_field("shared_count", 32'(want.shared),
						32'(m_axis_tdata[CNT_W +: CNT_W]));
					check_field("similarity", 32'(want.similarity),
						32'(m_axis_tdata[2*CNT_W +: SIM_W]));
					check_field("no_data", 32'(want.no_data), 32'(m_axis_tuser[0]));
				end
				ratios_seen++;
				recv_stall = steady ? 0 : $urandom_range(0, 3);
				// long hold-off so the block backs up into its input
				if (ratios_seen == 3 || ratios_seen == 50)
					recv_hold = HOLD_CYCLES;
			end
			if (recv_hold > 0) begin
				recv_hold--;
				m_axis_tready <= 1'b0;
			end else if (recv_stall > 0) begin
				recv_stall--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic queue_locus(input int fa, input int sa, input int fb, input int sb,
			input logic last);
		locus_t l;
		l.fa = ALLELE_W'(fa);
		l.sa = ALLELE_W'(sa);
		l.fb = ALLELE_W'(fb);
		l.sb = ALLELE_W'(sb);
		l.last = last;
		locus_queue.insert(locus_queue.size(), l);
		loci_queued++;
	endtask

	task automatic settle();
		while (loci_sent != loci_queued || expected_ratios.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(input logic mode);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= mode;
		@(posedge clk);
		cfg_we <= 1'b0;
		diploid_now = mode;
	endtask

	// small alphabet so matches and homozygotes are common
	function automatic int pick_allele(input int missing_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < missing_pct)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		return $urandom_range(1, 255);
	endfunction

	task automatic random_phase(input int n_items);
		int left;
		int len;
		int miss;
		logic brk;
		write_mode(1'($urandom_range(0, 1)));
		steady = ($urandom_range(0, 3) == 0);
		left = n_items;
		while (left > 0) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8);
			if (len > left)
				len = left;
			miss = ($urandom_range(0, 4) == 0) ? 60 : 8;
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 9) == 0) begin
					brk = (i == len - 1) || ($urandom_range(0, 1) == 1);
					queue_locus($urandom_range(0, 255), $urandom_range(0, 255),
						$urandom_range(0, 255), $urandom_range(0, 255), brk);
				end else begin
					queue_locus(pick_allele(miss), pick_allele(miss), pick_allele(miss),
						pick_allele(miss), i == len - 1);
				end
			end
			left -= len;
		end
		settle();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// diploid after reset
		queue_locus(1, 1, 1, 1, 1'b1);
		queue_locus(5, 5, 5, 7, 1'b0);
		queue_locus(5, 5, 7, 7, 1'b0);
		queue_locus(3, 9, 9, 9, 1'b0);
		queue_locus(3, 9, 9, 3, 1'b0);
		queue_locus(255, 255, 255, 255, 1'b0);
		queue_locus(0, 1, 1, 1, 1'b0);
		queue_locus(170, 85, 85, 170, 1'b1);
		queue_locus(0, 0, 0, 0, 1'b1);
		queue_locus(7, 7, 0, 7, 1'b1);
		queue_locus(2, 4, 6, 8, 1'b1);
		settle();

		write_mode(1'b0);
		queue_locus(1, 0, 1, 0, 1'b0);
		queue_locus(255, 3, 254, 3, 1'b0);
		queue_locus(0, 5, 5, 5, 1'b0);
		queue_locus(128, 1, 128, 2, 1'b1);
		queue_locus(0, 1, 1, 1, 1'b1);
		queue_locus(255, 255, 255, 255, 1'b1);
		// mode switch inside a pair keeps the totals
		queue_locus(6, 0, 6, 0, 1'b0);
		settle();
		write_mode(1'b1);
		queue_locus(6, 6, 6, 6, 1'b1);
		settle();

		for (int p = 0; p < 8; p++)
			random_phase(54);

		settle();
		if (failures == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
